// File: rtl/cross_spectrum_accumulator_macros.svh
// ----------------------------------------------------------------------------
// cross spectrum accumulator assertion macros
// concurrent checks clocked on aclk, off while aresetn is low
// ----------------------------------------------------------------------------
`ifndef CROSS_SPECTRUM_ACCUMULATOR_MACROS_SVH
`define CROSS_SPECTRUM_ACCUMULATOR_MACROS_SVH

// condition holds at every edge out of reset
`define CSA_ASSERT_HOLD(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define CSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/csa_pkg.sv
// ----------------------------------------------------------------------------
// csa_pkg
// shared types, widths and saturating adders of the cross spectrum accumulator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package csa_pkg;

    localparam int unsigned BINS_DEFAULT           = 1024;
    localparam int unsigned COMPONENT_BITS_DEFAULT = 24;

    localparam int unsigned SUM_W   = 64;
    localparam int unsigned POW_W   = 63;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned FRAMES_W = 8;

    localparam logic [FRAMES_W-1:0] BLOCK_FRAMES_RESET = 8'd5;

    localparam int unsigned OUT_FIELDS_W = 4 * SUM_W + 4 * POW_W + COUNT_W;
    localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // one set of four sums for one bin
    typedef struct packed {
        logic        [POW_W-1:0] power_b;
        logic        [POW_W-1:0] power_a;
        logic signed [SUM_W-1:0] cross_im;
        logic signed [SUM_W-1:0] cross_re;
    } acc_set_t;

    // one memory word: block sums and running totals of one bin
    typedef struct packed {
        acc_set_t tot;
        acc_set_t blk;
    } acc_entry_t;

    function automatic logic signed [SUM_W-1:0] sat_add_s(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] b
    );
        logic signed [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (s[SUM_W] != s[SUM_W-1]) begin
            return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return s[SUM_W-1:0];
    endfunction

    function automatic logic [POW_W-1:0] sat_add_p(
        input logic [POW_W-1:0] a,
        input logic [POW_W-1:0] b
    );
        logic [POW_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[POW_W] ? {POW_W{1'b1}} : s[POW_W-1:0];
    endfunction

    function automatic acc_set_t acc_add(input acc_set_t old, input acc_set_t inc);
        acc_set_t r;
        r.cross_re = sat_add_s(old.cross_re, inc.cross_re);
        r.cross_im = sat_add_s(old.cross_im, inc.cross_im);
        r.power_a  = sat_add_p(old.power_a, inc.power_a);
        r.power_b  = sat_add_p(old.power_b, inc.power_b);
        return r;
    endfunction

endpackage

// File: rtl/cross_spectrum_accumulator.sv
// ----------------------------------------------------------------------------
// cross_spectrum_accumulator
// path: each bin runs through stages 1 to 4 and the output register to m_tvalid
// throughput: one bin per cycle while the skid stage is free, four pipeline stages plus an output skid pair
// the rate is set by the one read and one write port of the per-bin sum memory
// reset: synchronous on aresetn, then a clearing pass over all BINS words, no input
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cross_spectrum_accumulator #(
    parameter int unsigned BINS           = csa_pkg::BINS_DEFAULT,
    parameter int unsigned COMPONENT_BITS = csa_pkg::COMPONENT_BITS_DEFAULT
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,

    // block length register
    input  logic                                    cfg_wr_en,
    input  logic [csa_pkg::FRAMES_W-1:0]            cfg_wr_data,

    // bin input: a_re, a_im, b_re, b_im from bit 0 up, zero pad on top
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((4*COMPONENT_BITS+7)/8)*8-1:0]   s_tdata,
    input  logic                                    s_tlast,   // last_bin
    input  logic                                    s_tuser,   // restart_totals

    // result: block_cross_re, block_cross_im, block_power_a, block_power_b,
    // total_cross_re, total_cross_im, total_power_a, total_power_b,
    // total_frame_count from bit 0 up, zero pad on top
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [csa_pkg::OUT_TDATA_W-1:0]         m_tdata,
    output logic                                    m_tlast,   // last_out
    output logic                                    m_tuser    // block_complete
);

    import csa_pkg::*;

    `include "cross_spectrum_accumulator_macros.svh"

    localparam int unsigned CB     = COMPONENT_BITS;
    localparam int unsigned AW     = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int unsigned PROD_W = 2 * CB;
    localparam int unsigned PW     = 2 * CB + 1;   // sum of two products
    localparam logic [AW-1:0] LAST_ADDR = AW'(BINS - 1);

    // control that rides along each bin through the pipe
    typedef struct packed {
        logic [AW-1:0]      addr;
        logic               last;
        logic               restart;
        logic               complete;
        logic [COUNT_W-1:0] tcount;
    } ctrl_t;

    // result beat held in the output pair
    typedef struct packed {
        acc_set_t           blk;
        acc_set_t           tot;
        logic [COUNT_W-1:0] tcount;
        logic               complete;
        logic               last;
    } beat_t;

    // ------------------------------------------------------------------------
    // configuration and per-frame control state
    // ------------------------------------------------------------------------
    logic [FRAMES_W-1:0] block_frames_reg;
    logic [AW-1:0]       bin_pos_reg,  bin_pos_next;
    logic [FRAMES_W-1:0] fib_reg,      fib_next;      // frames in block
    logic [COUNT_W-1:0]  fit_reg,      fit_next;      // frames in totals

    // clearing pass after reset
    logic                clr_busy_reg;
    logic [AW-1:0]       clr_addr_reg;

    // handshake
    logic                pipe_en;
    logic                in_acc;

    // control computed at acceptance
    logic                acc_complete;
    logic [COUNT_W-1:0]  acc_tcount;

    // stage 1: input capture
    logic                s1_valid_reg;
    ctrl_t               s1_ctrl_reg;
    logic signed [CB-1:0] s1_a_reg, s1_b_reg, s1_c_reg, s1_d_reg;

    // stage 2: products
    logic                s2_valid_reg;
    ctrl_t               s2_ctrl_reg;
    logic signed [PROD_W-1:0] s2_ac_reg, s2_bd_reg, s2_bc_reg, s2_ad_reg;
    logic signed [PROD_W-1:0] s2_aa_reg, s2_bb_reg, s2_cc_reg, s2_dd_reg;

    // stage 3: cross and power terms, memory word read
    logic                s3_valid_reg;
    ctrl_t               s3_ctrl_reg;
    logic signed [PW-1:0] s3_xre_reg, s3_xim_reg, s3_pa_reg, s3_pb_reg;
    acc_entry_t          rd_data_reg;

    // stage 4: accumulated sums, written back as they load
    logic                s4_valid_reg;
    ctrl_t               s4_ctrl_reg;
    acc_set_t            s4_blk_reg,   s4_blk_next;
    acc_set_t            s4_tot_reg,   s4_tot_next;

    // output register and skid stage
    logic                out_valid_reg;
    beat_t               out_reg;
    logic                skid_valid_reg;
    beat_t               skid_reg;
    beat_t               s4_beat;

    // memory
    acc_entry_t          acc_mem [BINS];
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    acc_entry_t          mem_wdata;

    // stage 4 combinational
    logic                fwd_hit;
    acc_entry_t          old_entry;
    acc_set_t            inc_set;
    acc_set_t            s4_blk_stored;

    // ------------------------------------------------------------------------
    // handshake: the pipe moves as one while the skid stage is free
    // ------------------------------------------------------------------------
    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en && !clr_busy_reg;
    assign in_acc   = s_tvalid && s_tready;

    // ------------------------------------------------------------------------
    // block length register
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_frames_reg <= BLOCK_FRAMES_RESET;
        end else if (cfg_wr_en) begin
            block_frames_reg <= cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------------
    // frame bookkeeping, resolved at the input beat
    // ------------------------------------------------------------------------
    // a zero or lowered block length completes the block on this frame
    assign acc_complete = ({1'b0, fib_reg} + 9'd1) >= {1'b0, block_frames_reg};

    always_comb begin
        if (s_tuser) begin
            acc_tcount = COUNT_W'(1);
        end else if (fit_reg == {COUNT_W{1'b1}}) begin
            acc_tcount = fit_reg;
        end else begin
            acc_tcount = fit_reg + COUNT_W'(1);
        end
    end

    always_comb begin
        bin_pos_next = bin_pos_reg;
        fib_next     = fib_reg;
        fit_next     = fit_reg;
        if (in_acc) begin
            if (s_tlast) begin
                bin_pos_next = '0;
                fib_next     = acc_complete ? '0 : fib_reg + FRAMES_W'(1);
                fit_next     = acc_tcount;
            end else if (bin_pos_reg == LAST_ADDR) begin
                // overlong frame wraps onto bin zero
                bin_pos_next = '0;
            end else begin
                bin_pos_next = bin_pos_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_pos_reg <= '0;
            fib_reg     <= '0;
            fit_reg     <= '0;
        end else begin
            bin_pos_reg <= bin_pos_next;
            fib_reg     <= fib_next;
            fit_reg     <= fit_next;
        end
    end

    // ------------------------------------------------------------------------
    // clearing pass over the sum memory, one word a cycle
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == LAST_ADDR) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // pipeline valid bits
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s1_valid_reg <= in_acc;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // ------------------------------------------------------------------------
    // pipeline payload
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            // stage 1: unpack the beat
            s1_ctrl_reg.addr     <= bin_pos_reg;
            s1_ctrl_reg.last     <= s_tlast;
            s1_ctrl_reg.restart  <= s_tuser;
            s1_ctrl_reg.complete <= acc_complete;
            s1_ctrl_reg.tcount   <= acc_tcount;
            s1_a_reg <= s_tdata[CB-1:0];
            s1_b_reg <= s_tdata[2*CB-1:CB];
            s1_c_reg <= s_tdata[3*CB-1:2*CB];
            s1_d_reg <= s_tdata[4*CB-1:3*CB];

            // stage 2: eight products
            s2_ctrl_reg <= s1_ctrl_reg;
            s2_ac_reg <= PROD_W'(s1_a_reg) * PROD_W'(s1_c_reg);
            s2_bd_reg <= PROD_W'(s1_b_reg) * PROD_W'(s1_d_reg);
            s2_bc_reg <= PROD_W'(s1_b_reg) * PROD_W'(s1_c_reg);
            s2_ad_reg <= PROD_W'(s1_a_reg) * PROD_W'(s1_d_reg);
            s2_aa_reg <= PROD_W'(s1_a_reg) * PROD_W'(s1_a_reg);
            s2_bb_reg <= PROD_W'(s1_b_reg) * PROD_W'(s1_b_reg);
            s2_cc_reg <= PROD_W'(s1_c_reg) * PROD_W'(s1_c_reg);
            s2_dd_reg <= PROD_W'(s1_d_reg) * PROD_W'(s1_d_reg);

            // stage 3: a times conj b, and the two powers
            s3_ctrl_reg <= s2_ctrl_reg;
            s3_xre_reg  <= PW'(s2_ac_reg) + PW'(s2_bd_reg);
            s3_xim_reg  <= PW'(s2_bc_reg) - PW'(s2_ad_reg);
            s3_pa_reg   <= PW'(s2_aa_reg) + PW'(s2_bb_reg);
            s3_pb_reg   <= PW'(s2_cc_reg) + PW'(s2_dd_reg);

            // stage 4: accumulated sums
            s4_ctrl_reg <= s3_ctrl_reg;
            s4_blk_reg  <= s4_blk_next;
            s4_tot_reg  <= s4_tot_next;
        end
    end

    // ------------------------------------------------------------------------
    // stage 4: accumulate with forwarding
    // the word for a bin is read as the bin enters stage 3; the bin one place
    // ahead writes at that same edge, so its stored value comes from stage 4
    // ------------------------------------------------------------------------
    // block sums are stored as zero once read out in a completing frame
    assign s4_blk_stored = s4_ctrl_reg.complete ? '0 : s4_blk_reg;

    always_comb begin
        fwd_hit   = s4_valid_reg && (s4_ctrl_reg.addr == s3_ctrl_reg.addr);
        old_entry = rd_data_reg;
        if (fwd_hit) begin
            old_entry.blk = s4_blk_stored;
            old_entry.tot = s4_tot_reg;
        end

        inc_set.cross_re = SUM_W'(s3_xre_reg);
        inc_set.cross_im = SUM_W'(s3_xim_reg);
        // powers are never negative, drop the sign bit
        inc_set.power_a  = POW_W'(s3_pa_reg[PW-2:0]);
        inc_set.power_b  = POW_W'(s3_pb_reg[PW-2:0]);

        s4_blk_next = acc_add(old_entry.blk, inc_set);
        s4_tot_next = s3_ctrl_reg.restart ? inc_set : acc_add(old_entry.tot, inc_set);
    end

    // ------------------------------------------------------------------------
    // sum memory: one write port, one registered read port
    // ------------------------------------------------------------------------
    always_comb begin
        if (clr_busy_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = pipe_en && s3_valid_reg;
            mem_waddr = s3_ctrl_reg.addr;
            mem_wdata.blk = s3_ctrl_reg.complete ? '0 : s4_blk_next;
            mem_wdata.tot = s4_tot_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            acc_mem[mem_waddr] <= mem_wdata;
        end
        if (pipe_en) begin
            rd_data_reg <= acc_mem[s2_ctrl_reg.addr];
        end
    end

    // ------------------------------------------------------------------------
    // output register with skid stage
    // ------------------------------------------------------------------------
    always_comb begin
        s4_beat.blk      = s4_blk_reg;
        s4_beat.tot      = s4_tot_reg;
        s4_beat.tcount   = s4_ctrl_reg.tcount;
        s4_beat.complete = s4_ctrl_reg.complete;
        s4_beat.last     = s4_ctrl_reg.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= s4_valid_reg;
            end
        end else if (s4_valid_reg) begin
            // output held, the stage 4 beat parks in the skid stage
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_reg <= skid_valid_reg ? skid_reg : s4_beat;
        end else if (!skid_valid_reg) begin
            skid_reg <= s4_beat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.last;
    assign m_tuser  = out_reg.complete;
    assign m_tdata  = {
        {(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
        out_reg.tcount,
        out_reg.tot.power_b,
        out_reg.tot.power_a,
        out_reg.tot.cross_im,
        out_reg.tot.cross_re,
        out_reg.blk.power_b,
        out_reg.blk.power_a,
        out_reg.blk.cross_im,
        out_reg.blk.cross_re
    };

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `CSA_ASSERT_HOLD(a_skid_behind_out, !skid_valid_reg || out_valid_reg, "skid beat without output beat")
    `CSA_ASSERT_HOLD(a_clear_pipe_empty, !clr_busy_reg || !(s1_valid_reg || s2_valid_reg || s3_valid_reg || s4_valid_reg), "bin in flight during clearing pass")
    `CSA_ASSERT_HOLD(a_block_count_range, fib_reg != {FRAMES_W{1'b1}}, "frames in block ran past the register range")
    `CSA_ASSERT_NEXT(a_frame_end_rewind, in_acc && s_tlast, bin_pos_reg == '0, "bin position not rewound at frame end")

endmodule
